@@ src/rcsp_pkg.sv @@
// Shared types and constants for the command stream parser.
// Used by rcsp_front, rcsp_queue, rcsp_back and resp_command_stream_parser.
package rcsp_pkg;

    localparam int DEF_MAX_ARRAY = 256;
    localparam int DEF_LEN_BITS  = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int CFG_W   = 9;

    localparam logic [PADDR_W-3:0] REG_MAX_ELEMENTS = '0;
    localparam logic [CFG_W-1:0]   MAX_ELEMENTS_RST = 9'd256;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_COUNT,
        PH_ELEM,
        PH_LEN,
        PH_PAYLOAD,
        PH_TRAIL_CR,
        PH_TRAIL_LF
    } phase_t;

    typedef enum logic [1:0] {
        NS_SPACE,
        NS_SIGN,
        NS_DIGITS,
        NS_DONE
    } num_stage_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD,
        KIND_ELEM_END,
        KIND_CMD_DONE,
        KIND_ABORT
    } kind_t;

    // Results caused by one request byte, in emit order: payload, element end,
    // command done; abort stands alone.
    typedef struct packed {
        logic       pay_v;
        logic       end_v;
        logic       cmp_v;
        logic       abt_v;
        logic [7:0] data;
        logic [7:0] index;
    } rcsp_rec_t;

    typedef struct packed {
        logic      valid;
        rcsp_rec_t rec;
    } rcsp_entry_t;

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

@@ src/rcsp_front.sv @@
// Front end: one request byte per cycle while q_full is low; runs the framing
// state machine and number-line reader and pushes a result record. Uses rcsp_pkg.
module rcsp_front #(
    parameter int MAX_ARRAY = rcsp_pkg::DEF_MAX_ARRAY,
    parameter int LEN_BITS  = rcsp_pkg::DEF_LEN_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [rcsp_pkg::CFG_W-1:0] max_elements,
    input  logic                       in_valid,
    input  logic [7:0]                 in_byte,
    input  logic                       q_full,
    output rcsp_pkg::rcsp_entry_t      push
);
    import rcsp_pkg::*;

    localparam int ACC_W = LEN_BITS + 1;
    localparam int CNT_W = $clog2(MAX_ARRAY + 1);
    localparam logic [CFG_W-1:0] ARRAY_LIM = CFG_W'(MAX_ARRAY);
    localparam logic [ACC_W-1:0] ACC_MAX = '1;

    phase_t               phase_reg, phase_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic                 neg_reg, neg_next;
    num_stage_t           stage_reg, stage_next;
    logic                 pcr_reg, pcr_next;
    logic [CNT_W-1:0]     el_left_reg, el_left_next;
    logic [7:0]           cur_elem_reg, cur_next;
    logic [LEN_BITS-1:0]  bytes_left_reg, bytes_left_next;

    logic                 accept;
    logic                 is_digit;
    logic                 line_end;
    logic [3:0]           dig4;
    logic [ACC_W+3:0]     acc_x10;
    logic [ACC_W-1:0]     acc_dig;
    num_stage_t           stage_cr, stage_ln;
    logic [ACC_W-1:0]     acc_ln;
    logic                 neg_ln, pcr_ln;
    logic [CFG_W-1:0]     lim;
    logic                 count_ok;
    logic [LEN_BITS-1:0]  len_val;
    rcsp_rec_t            rec;
    logic                 run_hunt, run_elem, run_finish;

    assign accept   = in_valid && !q_full;
    assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    assign line_end = pcr_reg && (in_byte == CH_LF);
    assign dig4     = 4'(in_byte - CH_ZERO);
    assign acc_x10  = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                    + {{ACC_W{1'b0}}, dig4};
    assign acc_dig  = (|acc_x10[ACC_W+3:ACC_W]) ? ACC_MAX : acc_x10[ACC_W-1:0];

    assign lim      = (max_elements > ARRAY_LIM) ? ARRAY_LIM : max_elements;
    assign count_ok = !neg_reg && (acc_reg != '0) && (acc_reg <= ACC_W'(lim));
    assign len_val  = neg_reg ? '0 :
                      (acc_reg[LEN_BITS] ? '1 : acc_reg[LEN_BITS-1:0]);

    // number line reader: held CR is fed as white space before this byte
    always_comb
    begin
        stage_cr = stage_reg;
        if (pcr_reg && (stage_reg == NS_SIGN || stage_reg == NS_DIGITS))
        begin
            stage_cr = NS_DONE;
        end
        acc_ln   = acc_reg;
        neg_ln   = neg_reg;
        stage_ln = stage_cr;
        pcr_ln   = 1'b0;
        if (line_end)
        begin
            stage_ln = stage_reg;
        end
        else if (in_byte == CH_CR)
        begin
            pcr_ln = 1'b1;
        end
        else
        begin
            case (stage_cr)
                NS_SPACE:
                begin
                    if (!is_space(in_byte))
                    begin
                        if (in_byte == CH_PLUS)
                        begin
                            stage_ln = NS_SIGN;
                        end
                        else if (in_byte == CH_MINUS)
                        begin
                            neg_ln   = 1'b1;
                            stage_ln = NS_SIGN;
                        end
                        else if (is_digit)
                        begin
                            acc_ln   = acc_dig;
                            stage_ln = NS_DIGITS;
                        end
                        else
                        begin
                            stage_ln = NS_DONE;
                        end
                    end
                end
                NS_SIGN, NS_DIGITS:
                begin
                    if (is_digit)
                    begin
                        acc_ln   = acc_dig;
                        stage_ln = NS_DIGITS;
                    end
                    else
                    begin
                        stage_ln = NS_DONE;
                    end
                end
                default:
                begin
                    stage_ln = stage_cr;
                end
            endcase
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        acc_next        = acc_reg;
        neg_next        = neg_reg;
        stage_next      = stage_reg;
        pcr_next        = pcr_reg;
        el_left_next    = el_left_reg;
        cur_next        = cur_elem_reg;
        bytes_left_next = bytes_left_reg;
        rec             = '0;
        rec.index       = cur_elem_reg;
        run_hunt        = 1'b0;
        run_elem        = 1'b0;
        run_finish      = 1'b0;

        case (phase_reg)
            PH_HUNT:
            begin
                run_hunt = 1'b1;
            end
            PH_COUNT:
            begin
                acc_next   = acc_ln;
                neg_next   = neg_ln;
                stage_next = stage_ln;
                pcr_next   = pcr_ln;
                if (line_end)
                begin
                    if (count_ok)
                    begin
                        el_left_next = acc_reg[CNT_W-1:0];
                        cur_next     = '0;
                        phase_next   = PH_ELEM;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
            end
            PH_ELEM:
            begin
                run_elem = 1'b1;
            end
            PH_LEN:
            begin
                acc_next   = acc_ln;
                neg_next   = neg_ln;
                stage_next = stage_ln;
                pcr_next   = pcr_ln;
                if (line_end)
                begin
                    bytes_left_next = len_val;
                    if (len_val == '0)
                    begin
                        run_finish = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                rec.pay_v       = 1'b1;
                rec.data        = in_byte;
                bytes_left_next = bytes_left_reg - LEN_BITS'(1);
                if (bytes_left_reg == LEN_BITS'(1))
                begin
                    run_finish = 1'b1;
                end
            end
            PH_TRAIL_CR:
            begin
                if (in_byte == CH_CR)
                begin
                    phase_next = PH_TRAIL_LF;
                end
                else if (el_left_reg == '0)
                begin
                    run_hunt = 1'b1;
                end
                else
                begin
                    run_elem = 1'b1;
                end
            end
            PH_TRAIL_LF:
            begin
                // lone CR: it is replayed first, then this byte hunts
                if (in_byte == CH_LF)
                begin
                    phase_next = (el_left_reg == '0) ? PH_HUNT : PH_ELEM;
                end
                else
                begin
                    if (el_left_reg != '0)
                    begin
                        rec.abt_v    = 1'b1;
                        el_left_next = '0;
                    end
                    run_hunt = 1'b1;
                end
            end
            default:
            begin
                run_hunt = 1'b1;
            end
        endcase

        if (run_finish)
        begin
            rec.end_v    = 1'b1;
            el_left_next = el_left_reg - CNT_W'(1);
            if (el_left_reg == CNT_W'(1))
            begin
                rec.cmp_v = 1'b1;
            end
            cur_next   = cur_elem_reg + 8'd1;
            phase_next = PH_TRAIL_CR;
        end

        if (run_elem)
        begin
            if (in_byte == CH_DOLLAR)
            begin
                acc_next   = '0;
                neg_next   = 1'b0;
                stage_next = NS_SPACE;
                pcr_next   = 1'b0;
                phase_next = PH_LEN;
            end
            else
            begin
                rec.abt_v    = 1'b1;
                el_left_next = '0;
                run_hunt     = 1'b1;
            end
        end

        if (run_hunt)
        begin
            if (in_byte == CH_STAR)
            begin
                acc_next   = '0;
                neg_next   = 1'b0;
                stage_next = NS_SPACE;
                pcr_next   = 1'b0;
                phase_next = PH_COUNT;
            end
            else
            begin
                phase_next = PH_HUNT;
            end
        end
    end

    assign push.valid = accept && (rec.pay_v || rec.end_v || rec.cmp_v || rec.abt_v);
    assign push.rec   = rec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            acc_reg        <= '0;
            neg_reg        <= 1'b0;
            stage_reg      <= NS_SPACE;
            pcr_reg        <= 1'b0;
            el_left_reg    <= '0;
            cur_elem_reg   <= '0;
            bytes_left_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            acc_reg        <= acc_next;
            neg_reg        <= neg_next;
            stage_reg      <= stage_next;
            pcr_reg        <= pcr_next;
            el_left_reg    <= el_left_next;
            cur_elem_reg   <= cur_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

`ifndef SYNTHESIS
    a_payload_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> bytes_left_reg != '0)
        else $error("payload phase with no bytes left");

    a_elem_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ELEM |-> el_left_reg != '0)
        else $error("element phase with no elements left");

    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> (in_valid && !q_full))
        else $error("record pushed without an accepted byte");
`endif

endmodule

@@ src/rcsp_queue.sv @@
// Short record queue between the parser front end and the result sequencer.
// Uses rcsp_pkg for the record type and depth.
module rcsp_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rcsp_pkg::rcsp_entry_t push,
    input  logic                  pop,
    output rcsp_pkg::rcsp_entry_t head,
    output logic                  full
);
    import rcsp_pkg::*;

    rcsp_rec_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.rec   = mem_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from empty queue");
`endif

endmodule

@@ src/rcsp_back.sv @@
// Result sequencer: walks the head record and issues its results one per
// cycle on the output channel while out_stall is low. Uses rcsp_pkg.
module rcsp_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rcsp_pkg::rcsp_entry_t head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            kind,
    output logic [7:0]            data,
    output logic [7:0]            element_index,
    output logic                  last
);
    import rcsp_pkg::*;

    logic  sent_pay_reg, sent_end_reg;
    kind_t cur_kind;
    logic  cur_last;
    logic  fire;

    always_comb
    begin
        if (head.rec.pay_v && !sent_pay_reg)
        begin
            cur_kind = KIND_PAYLOAD;
            cur_last = !head.rec.end_v && !head.rec.cmp_v;
        end
        else if (head.rec.end_v && !sent_end_reg)
        begin
            cur_kind = KIND_ELEM_END;
            cur_last = !head.rec.cmp_v;
        end
        else if (head.rec.cmp_v)
        begin
            cur_kind = KIND_CMD_DONE;
            cur_last = 1'b1;
        end
        else
        begin
            cur_kind = KIND_ABORT;
            cur_last = 1'b1;
        end
    end

    assign out_valid     = head.valid;
    assign kind          = cur_kind;
    assign data          = (cur_kind == KIND_PAYLOAD) ? head.rec.data : 8'd0;
    assign element_index = head.rec.index;
    assign last          = cur_last;
    assign fire          = out_valid && !out_stall;
    assign pop           = fire && cur_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_pay_reg <= 1'b0;
            sent_end_reg <= 1'b0;
        end
        else if (pop)
        begin
            sent_pay_reg <= 1'b0;
            sent_end_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (cur_kind == KIND_PAYLOAD)
            begin
                sent_pay_reg <= 1'b1;
            end
            if (cur_kind == KIND_ELEM_END)
            begin
                sent_end_reg <= 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_record_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !cur_last) |=> out_valid)
        else $error("record dropped before its last result");

    a_final_kinds_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (cur_kind == KIND_ABORT || cur_kind == KIND_CMD_DONE)) |-> cur_last)
        else $error("abort or command done not flagged last");

    a_end_sent_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && sent_end_reg) |-> head.rec.cmp_v)
        else $error("element end sent but record continues without done");
`endif

endmodule

@@ src/resp_command_stream_parser.sv @@
// Command stream parser top level: register port, front end, queue, sequencer.
// Each result is registered in the record queue and offered from its head.
// Throughput: one request byte per cycle while in_stall is low; a byte with two
// or three results holds the output for each; a 4-entry record queue absorbs it.
// Reset: asynchronous, active low; parser idles hunting, max_elements = 256.
// Depends on rcsp_pkg, rcsp_front, rcsp_queue, rcsp_back.
module resp_command_stream_parser #(
    parameter int MAX_ARRAY = rcsp_pkg::DEF_MAX_ARRAY,
    parameter int LEN_BITS  = rcsp_pkg::DEF_LEN_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rcsp_pkg::PADDR_W-1:0] paddr,
    input  logic [rcsp_pkg::PDATA_W-1:0] pwdata,
    output logic [rcsp_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   in_byte,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   kind,
    output logic [7:0]                   data,
    output logic [7:0]                   element_index,
    output logic                         last
);
    import rcsp_pkg::*;

    logic [CFG_W-1:0] max_elements_reg;
    logic             reg_sel;
    logic             q_full;
    logic             pop;
    rcsp_entry_t      push;
    rcsp_entry_t      head;

    assign pready   = 1'b1;
    assign reg_sel  = (paddr[PADDR_W-1:2] == REG_MAX_ELEMENTS);
    assign prdata   = reg_sel ? {{(PDATA_W-CFG_W){1'b0}}, max_elements_reg} : '0;
    assign in_stall = q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_elements_reg <= MAX_ELEMENTS_RST;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            max_elements_reg <= pwdata[CFG_W-1:0];
        end
    end

    rcsp_front #(
        .MAX_ARRAY (MAX_ARRAY),
        .LEN_BITS  (LEN_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .max_elements (max_elements_reg),
        .in_valid     (in_valid),
        .in_byte      (in_byte),
        .q_full       (q_full),
        .push         (push)
    );

    rcsp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .full  (q_full)
    );

    rcsp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .data          (data),
        .element_index (element_index),
        .last          (last)
    );

endmodule

@@ tb/tb_resp_command_stream_parser.sv @@
// Self-checking testbench for resp_command_stream_parser: directed and random request
// streams, random idling on both channels, and checks of every result against a predictor.
// Depends on rcsp_pkg and the RTL of resp_command_stream_parser.
module tb_resp_command_stream_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import rcsp_pkg::*;

    localparam logic [63:0] ACC_MAX = (64'd1 << (DEF_LEN_BITS + 1)) - 64'd1;
    localparam logic [63:0] LEN_MAX = (64'd1 << DEF_LEN_BITS) - 64'd1;
    localparam logic [PADDR_W-1:0] CFG_ADDR = {REG_MAX_ELEMENTS, 2'b00};
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [7:0] index;
        logic       last;
    } parse_event_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         in_byte = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         kind;
    logic [7:0]         data;
    logic [7:0]         element_index;
    logic               last;

    // parser state tracked by the testbench
    logic [CFG_W-1:0]        max_elems;
    phase_t                  ph;
    logic [DEF_LEN_BITS:0]   acc;
    logic                    neg;
    num_stage_t              nstage;
    logic                    cr_seen;
    logic [8:0]              elems_left;
    logic [7:0]              cur_elem;
    logic [DEF_LEN_BITS-1:0] len_left;

    parse_event_t byte_events[$];
    parse_event_t parser_events[$];
    parse_event_t head_event;
    logic [7:0]   tx_bytes[$];

    int mismatches = 0;
    int quiet_cycles = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    bit steady = 1'b0;

    resp_command_stream_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .data          (data),
        .element_index (element_index),
        .last          (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void flag_mismatch(string msg);
        if (mismatches < 10)
        begin
            $display("%s", msg);
        end
        mismatches++;
    endfunction

    // ---------------- predictor ----------------

    function automatic void predictor_reset();
        max_elems  = MAX_ELEMENTS_RST;
        ph         = PH_HUNT;
        acc        = '0;
        neg        = 1'b0;
        nstage     = NS_SPACE;
        cr_seen    = 1'b0;
        elems_left = '0;
        cur_elem   = '0;
        len_left   = '0;
    endfunction

    function automatic int eff_limit();
        return (max_elems > DEF_MAX_ARRAY) ? DEF_MAX_ARRAY : int'(max_elems);
    endfunction

    function automatic void note_event(kind_t k, logic [7:0] d, logic [7:0] idx);
        parse_event_t ev;
        if (byte_events.size() < 3)
        begin
            ev.kind  = k;
            ev.data  = (k == KIND_PAYLOAD) ? d : 8'h00;
            ev.index = idx;
            ev.last  = 1'b0;
            byte_events.insert(byte_events.size(), ev);
        end
    endfunction

    function automatic void number_reset();
        acc     = '0;
        neg     = 1'b0;
        nstage  = NS_SPACE;
        cr_seen = 1'b0;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic void number_feed(logic [7:0] c);
        logic [63:0] v;
        if (nstage == NS_DONE)
        begin
            return;
        end
        if (nstage == NS_SPACE)
        begin
            if (is_blank(c))
            begin
                return;
            end
            if (c == CH_PLUS)
            begin
                nstage = NS_SIGN;
                return;
            end
            if (c == CH_MINUS)
            begin
                neg = 1'b1;
                nstage = NS_SIGN;
                return;
            end
        end
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            v = acc;
            v = v * 64'd10 + (c - CH_ZERO);
            if (v > ACC_MAX)
            begin
                v = ACC_MAX;
            end
            acc = v[DEF_LEN_BITS:0];
            nstage = NS_DIGITS;
        end
        else
        begin
            nstage = NS_DONE;
        end
    endfunction

    // true when CR LF closes the line
    function automatic bit line_byte(logic [7:0] c);
        if (cr_seen)
        begin
            cr_seen = 1'b0;
            if (c == CH_LF)
            begin
                return 1'b1;
            end
            number_feed(CH_CR);
        end
        if (c == CH_CR)
        begin
            cr_seen = 1'b1;
        end
        else
        begin
            number_feed(c);
        end
        return 1'b0;
    endfunction

    function automatic void close_element();
        note_event(KIND_ELEM_END, 8'h00, cur_elem);
        elems_left = elems_left - 9'd1;
        if (elems_left == 0)
        begin
            note_event(KIND_CMD_DONE, 8'h00, cur_elem);
        end
        cur_elem = cur_elem + 8'd1;
        ph = PH_TRAIL_CR;
    endfunction

    function automatic void parse_byte(logic [7:0] c);
        bit busy;
        logic [63:0] n;
        byte_events.delete();
        busy = 1'b1;
        while (busy)
        begin
            case (ph)
                PH_HUNT:
                begin
                    if (c == CH_STAR)
                    begin
                        number_reset();
                        ph = PH_COUNT;
                    end
                    busy = 1'b0;
                end
                PH_COUNT:
                begin
                    if (line_byte(c))
                    begin
                        if (!neg && acc >= 1 && acc <= eff_limit())
                        begin
                            elems_left = acc[8:0];
                            cur_elem = '0;
                            ph = PH_ELEM;
                        end
                        else
                        begin
                            ph = PH_HUNT;
                        end
                    end
                    busy = 1'b0;
                end
                PH_ELEM:
                begin
                    if (c == CH_DOLLAR)
                    begin
                        number_reset();
                        ph = PH_LEN;
                        busy = 1'b0;
                    end
                    else
                    begin
                        note_event(KIND_ABORT, 8'h00, cur_elem);
                        elems_left = '0;
                        ph = PH_HUNT;
                    end
                end
                PH_LEN:
                begin
                    if (line_byte(c))
                    begin
                        n = neg ? 64'd0 : 64'(acc);
                        if (n > LEN_MAX)
                        begin
                            n = LEN_MAX;
                        end
                        len_left = n[DEF_LEN_BITS-1:0];
                        if (n == 0)
                        begin
                            close_element();
                        end
                        else
                        begin
                            ph = PH_PAYLOAD;
                        end
                    end
                    busy = 1'b0;
                end
                PH_PAYLOAD:
                begin
                    note_event(KIND_PAYLOAD, c, cur_elem);
                    len_left = len_left - 1'b1;
                    if (len_left == 0)
                    begin
                        close_element();
                    end
                    busy = 1'b0;
                end
                PH_TRAIL_CR:
                begin
                    if (c == CH_CR)
                    begin
                        ph = PH_TRAIL_LF;
                        busy = 1'b0;
                    end
                    else
                    begin
                        ph = (elems_left == 0) ? PH_HUNT : PH_ELEM;
                    end
                end
                PH_TRAIL_LF:
                begin
                    ph = (elems_left == 0) ? PH_HUNT : PH_ELEM;
                    if (c == CH_LF)
                    begin
                        busy = 1'b0;
                    end
                    else if (ph == PH_ELEM)
                    begin
                        // the held CR is replayed first and cannot start an element
                        note_event(KIND_ABORT, 8'h00, cur_elem);
                        elems_left = '0;
                        ph = PH_HUNT;
                    end
                end
                default:
                begin
                    ph = PH_HUNT;
                end
            endcase
        end
        if (byte_events.size() > 0)
        begin
            byte_events[byte_events.size() - 1].last = 1'b1;
        end
        foreach (byte_events[i])
        begin
            parser_events.insert(parser_events.size(), byte_events[i]);
        end
    endfunction

    // ---------------- request stream building ----------------

    function automatic void put_char(logic [7:0] c);
        tx_bytes.insert(tx_bytes.size(), c);
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            tx_bytes.insert(tx_bytes.size(), s[i]);
        end
    endfunction

    function automatic void put_num_line(longint v, bit fancy);
        int nws;
        if (fancy)
        begin
            nws = $urandom_range(0, 2);
            repeat (nws)
            begin
                case ($urandom_range(0, 4))
                    0: put_char(CH_SPACE);
                    1: put_char(CH_TAB);
                    2: put_char(8'h0B);
                    3: put_char(8'h0C);
                    default: put_char(CH_LF);
                endcase
            end
        end
        if (v < 0)
        begin
            put_char(CH_MINUS);
        end
        else if (fancy && $urandom_range(0, 3) == 0)
        begin
            put_char(CH_PLUS);
        end
        put_text($sformatf("%0d", (v < 0) ? -v : v));
        if (fancy && $urandom_range(0, 4) == 0)
        begin
            put_char(8'(8'h61 + $urandom_range(0, 25)));
        end
        put_char(CH_CR);
        put_char(CH_LF);
    endfunction

    function automatic void put_random_command(int lim);
        int n;
        int hi;
        int roll;
        int elems;
        int len;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                put_char(8'($urandom_range(0, 255)));
            end
        end
        hi = (lim < 5) ? lim : 5;
        if (hi < 1)
        begin
            hi = 1;
        end
        roll = $urandom_range(0, 99);
        if (roll < 85)
        begin
            n = $urandom_range(1, hi);
        end
        else if (roll < 90)
        begin
            n = 0;
        end
        else if (roll < 95)
        begin
            n = $urandom_range(1, 3);
            n = -n;
        end
        else
        begin
            n = lim + 1;
        end
        put_char(CH_STAR);
        put_num_line(n, $urandom_range(0, 2) == 0);
        elems = (n > 0) ? n : $urandom_range(0, 2);
        repeat (elems)
        begin
            if ($urandom_range(0, 99) < 6)
            begin
                put_char(8'($urandom_range(0, 255)));
            end
            else
            begin
                put_char(CH_DOLLAR);
            end
            roll = $urandom_range(0, 99);
            if (roll < 70)
            begin
                len = $urandom_range(0, 6);
            end
            else if (roll < 85)
            begin
                len = $urandom_range(1, 9);
                len = -len;
            end
            else
            begin
                len = $urandom_range(7, 24);
            end
            put_num_line(len, $urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++)
            begin
                put_char(8'($urandom_range(0, 255)));
            end
            roll = $urandom_range(0, 9);
            if (roll < 8)
            begin
                put_char(CH_CR);
                put_char(CH_LF);
            end
            else if (roll == 8)
            begin
                put_char(CH_CR);
            end
        end
    endfunction

    // ---------------- drivers ----------------

    function automatic bit take_break();
        return !steady && ($urandom_range(0, 99) < 13);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while (take_break())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        parse_byte(b);
    endtask

    task automatic send_tx();
        for (int i = 0; i < tx_bytes.size(); i++)
        begin
            send_byte(tx_bytes[i]);
        end
        tx_bytes.delete();
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (parser_events.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_W-1:0] value);
        wait_drained();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR;
        pwdata  <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        max_elems = value;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        if (prdata !== PDATA_W'(value))
        begin
            flag_mismatch($sformatf("max_elements readback: expected %0d got %0d",
                                    value, prdata));
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic return_to_hunt();
        for (int k = 0; k < 64 && ph != PH_HUNT; k++)
        begin
            send_byte(CH_CR);
            send_byte(CH_LF);
        end
    endtask

    task automatic run_random_bytes(int target);
        int sent;
        sent = 0;
        while (sent < target)
        begin
            put_random_command(eff_limit());
            sent += tx_bytes.size();
            send_tx();
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_basic_commands();
        cfg_write(MAX_ELEMENTS_RST);
        put_text("*2\r\n$3\r\nGET\r\n$1\r\nk\r\n");
        put_text("*1\r\n$2\r\n");
        put_char(8'h00);
        put_char(8'hFF);
        put_text("\r\n");
        send_tx();
    endtask

    task automatic test_number_forms();
        put_text("*\t +2xy\r\n$");
        put_char(8'h0B);
        put_char(8'h0C);
        put_text("03 z\r\nab\r\n");
        put_text("*2\r\n$\r1\rq\r\nc\r\n$+\r\n");
        put_text("*+1\r\n$-0\r\n");
        send_tx();
    endtask

    task automatic test_zero_and_negative_length();
        put_text("*3\r\n$0\r\n$-4\r\n$1\r\nz\r\n");
        send_tx();
    endtask

    task automatic test_bad_counts();
        put_text("*0\r\n$1\r\nA\r\n*-1\r\n$1\r\nB\r\n*257\r\n");
        put_text("*123456789012345678901\r\n*1\r\n$1\r\nC\r\n");
        send_tx();
    endtask

    task automatic test_missing_dollar();
        put_text("*2\r\n$1\r\na\r\nX$1\r\nb\r\n");
        put_text("*1\r\n*1\r\n$1\r\nc\r\n");
        put_text("*1\r\n\r\n");
        send_tx();
    endtask

    task automatic test_trailer_forms();
        put_text("*2\r\n$1\r\na$1\r\nb");
        put_text("*1\r\n$1\r\nd\r*1\r\n$1\r\ne\r\n");
        put_text("*2\r\n$1\r\nf\r$1\r\ng\r\n");
        send_tx();
    endtask

    task automatic test_count_limits();
        cfg_write(9'd1);
        put_text("*1\r\n$2\r\nhi\r\n*2\r\n$1\r\na\r\n$1\r\nb\r\n");
        send_tx();
        cfg_write(9'd0);
        put_text("*1\r\n$1\r\nz\r\n");
        send_tx();
        cfg_write(9'd511);
        return_to_hunt();
        steady = 1'b1;
        // a count of 256 is taken: two empty elements, then an abort
        put_text("*256\r\n$0\r\n$0\r\nX");
        put_text("*257\r\n$1\r\nq\r\n");
        send_tx();
        steady = 1'b0;
    endtask

    task automatic test_output_backpressure();
        hold_req++;
        put_text("*1\r\n$40\r\n");
        repeat (40)
        begin
            put_char(8'($urandom_range(0, 255)));
        end
        put_text("\r\n");
        send_tx();
    endtask

    task automatic test_random_traffic();
        cfg_write(9'd5);
        run_random_bytes(20);
        cfg_write(9'd256);
        steady = 1'b1;
        run_random_bytes(30);
        steady = 1'b0;
        cfg_write(CFG_W'($urandom_range(1, 511)));
        run_random_bytes(20);
        cfg_write(9'd2);
        run_random_bytes(20);
    endtask

    // leaves the parser inside a saturated payload, so it runs last
    task automatic test_oversized_length();
        return_to_hunt();
        put_text("*1\r\n$99999999999999999999\r\n");
        repeat (8)
        begin
            put_char(8'($urandom_range(0, 255)));
        end
        send_tx();
    endtask

    // ---------------- result side ----------------

    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= take_break();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (parser_events.size() == 0)
            begin
                flag_mismatch($sformatf(
                    "unexpected result: kind=%0d data=%h index=%0d last=%0b",
                    kind, data, element_index, last));
            end
            else
            begin
                head_event = parser_events.pop_front();
                if (kind !== head_event.kind || data !== head_event.data ||
                    element_index !== head_event.index || last !== head_event.last)
                begin
                    flag_mismatch($sformatf(
                        "result: expected kind=%0d data=%h index=%0d last=%0b, got %0d %h %0d %0b",
                        head_event.kind, head_event.data, head_event.index, head_event.last,
                        kind, data, element_index, last));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        predictor_reset();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_basic_commands();
        test_number_forms();
        test_zero_and_negative_length();
        test_bad_counts();
        test_missing_dollar();
        test_trailer_forms();
        test_count_limits();
        test_output_backpressure();
        test_random_traffic();
        test_oversized_length();
        wait_drained();
        if (mismatches == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ resp_command_stream_parser.f @@
src/rcsp_pkg.sv
src/rcsp_front.sv
src/rcsp_queue.sv
src/rcsp_back.sv
src/resp_command_stream_parser.sv
tb/tb_resp_command_stream_parser.sv
